### rtl/ptpu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the PNG/TIFF predictor undo unit.
// No dependencies.
package ptpu_pkg;

  localparam int LINE_BYTES      = 4096;
  localparam int ADDR_W          = $clog2(LINE_BYTES);
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int STRIDE_W        = $clog2(MAX_PIXEL_BYTES);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPC     = 3'd3;

  // Predictor modes
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_HORIZ = 2'd1;
  localparam logic [1:0] MODE_PNG   = 2'd2;

  // PNG row filter tags
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // Stream status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_TAG = 2'd1;
  localparam logic [1:0] ST_PARTIAL = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [1:0]  RST_MODE    = MODE_PASS;
  localparam logic [12:0] RST_COLUMNS = 13'd1;
  localparam logic [2:0]  RST_COLORS  = 3'd1;
  localparam logic [4:0]  RST_BPC     = 5'd8;

  typedef struct packed {
    logic                png;
    logic                tiff;
    logic                bad_len;
    logic [ADDR_W-1:0]   last_pos;
    logic [STRIDE_W-1:0] stride_m1;
  } geom_t;

  function automatic logic [STRIDE_W-1:0] clamp_stride_m1(logic [15:0] s);
    logic [STRIDE_W-1:0] r;
    if (s <= 16'd1) begin
      r = '0;
    end else if (s >= 16'(MAX_PIXEL_BYTES)) begin
      r = STRIDE_W'(MAX_PIXEL_BYTES - 1);
    end else begin
      r = STRIDE_W'(s - 16'd1);
    end
    return r;
  endfunction

  // Row geometry from the configuration registers
  function automatic geom_t calc_geom(logic [1:0] mode, logic [12:0] cols,
                                      logic [2:0] colors, logic [4:0] bpc);
    geom_t       g;
    logic [20:0] bits;
    logic [17:0] row_png;
    logic [15:0] row_tiff;
    logic [17:0] row_len;
    logic [7:0]  pix_bits;
    g        = '0;
    bits     = 21'(cols) * 21'(colors) * 21'(bpc);
    row_png  = 18'((bits + 21'd7) >> 3);
    row_tiff = 16'(cols) * 16'(colors);
    pix_bits = 8'(colors) * 8'(bpc);
    g.png    = (mode == MODE_PNG);
    g.tiff   = (mode == MODE_HORIZ) && (bpc == 5'd8);
    if (g.png) begin
      row_len     = row_png;
      g.stride_m1 = clamp_stride_m1(16'(pix_bits >> 3));
    end else begin
      row_len     = 18'(row_tiff);
      g.stride_m1 = clamp_stride_m1(16'(colors));
    end
    g.bad_len  = (row_len == '0) || (row_len > 18'(LINE_BYTES));
    g.last_pos = ADDR_W'(row_len - 18'd1);
    return g;
  endfunction

  function automatic logic [9:0] abs10(logic signed [9:0] v);
    return v[9] ? 10'(-v) : 10'(v);
  endfunction

  function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] r;
    pa = abs10(signed'({2'b00, b}) - signed'({2'b00, c}));
    pb = abs10(signed'({2'b00, a}) - signed'({2'b00, c}));
    pc = abs10(signed'({2'b00, a}) + signed'({2'b00, b}) - signed'({1'b0, c, 1'b0}));
    if (pa <= pb && pa <= pc) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

### rtl/png_tiff_predictor_undo_unit.sv
`timescale 1ns / 1ps
// Top level of the PNG/TIFF predictor undo unit: line buffer, pixel history and control.
// Depends on ptpu_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one decompressed byte and an
//   end-of-stream flag per transaction. Every accepted byte yields exactly one
//   result transaction on the output channel (out_valid_o / out_stall_i): the
//   reconstructed byte, a byte_valid flag (low for a PNG row tag), stream_done
//   and the sticky stream status.
//   out_valid_o rises in the cycle after input acceptance. Throughput is one
//   byte per cycle unless the receiver stalls; the previous-row line buffer is
//   a 4096x8 memory with a registered read, prefetched at the next row position
//   so its data is ready when the byte arrives, with a bypass on a write hit.
//   When the receiver stalls, the output register holds its transaction and
//   in_stall_o rises, so no new byte enters until the result is taken.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always ready; any write
//   to a defined register restarts the stream. Reset and end of stream restart
//   the stream as well; the line buffer is not swept, a first-row flag makes its
//   content read as zero until a full row has been written.
module png_tiff_predictor_undo_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           end_of_stream_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_valid_o,
  output logic                           stream_done_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ptpu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ptpu_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ptpu_pkg::*;

  // Configuration
  logic [1:0]  mode_q, mode_d;
  logic [12:0] cols_q, cols_d;
  logic [2:0]  colors_q, colors_d;
  logic [4:0]  bpc_q, bpc_d;
  geom_t       geom_q, geom_d;
  logic        cfg_write;
  logic        cfg_restart;

  // Stream state
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [2:0]        filt_q, filt_d;
  logic              await_q, await_d;
  logic [1:0]        err_q, err_d;
  logic              seen_q, seen_d;
  logic [7:0]        rc_q [MAX_PIXEL_BYTES];
  logic [7:0]        rc_d [MAX_PIXEL_BYTES];
  logic [7:0]        rp_q [MAX_PIXEL_BYTES];
  logic [7:0]        rp_d [MAX_PIXEL_BYTES];

  // Line buffer
  logic [7:0]        prior_mem [LINE_BYTES];
  logic [7:0]        mem_rdata_q;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  // Output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              byte_valid_q, byte_valid_d;
  logic              done_q;
  logic [1:0]        status_q;

  logic              in_acc;
  logic              left_ok;
  logic [7:0]        a_val;
  logic [7:0]        b_val;
  logic [7:0]        c_val;
  logic [7:0]        pred;
  logic [8:0]        avg_sum;
  logic [1:0]        err_v;
  logic              restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;
  assign cfg_restart = cfg_write && (cfg_index_i <= REG_BPC);
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    mode_d   = mode_q;
    cols_d   = cols_q;
    colors_d = colors_q;
    bpc_d    = bpc_q;
    if (cfg_write) begin
      case (cfg_index_i)
        REG_MODE:    mode_d   = cfg_data_i[1:0];
        REG_COLUMNS: cols_d   = cfg_data_i[12:0];
        REG_COLORS:  colors_d = cfg_data_i[2:0];
        REG_BPC:     bpc_d    = cfg_data_i[4:0];
        default: ;
      endcase
    end
    geom_d = calc_geom(mode_d, cols_d, colors_d, bpc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_MODE;
      cols_q   <= RST_COLUMNS;
      colors_q <= RST_COLORS;
      bpc_q    <= RST_BPC;
      geom_q   <= calc_geom(RST_MODE, RST_COLUMNS, RST_COLORS, RST_BPC);
    end else begin
      mode_q   <= mode_d;
      cols_q   <= cols_d;
      colors_q <= colors_d;
      bpc_q    <= bpc_d;
      geom_q   <= geom_d;
    end
  end

  // Neighbor bytes: left (a), above (b), upper left (c)
  assign left_ok = pos_q > ADDR_W'(geom_q.stride_m1);
  assign a_val   = left_ok ? rc_q[geom_q.stride_m1] : 8'd0;
  assign c_val   = left_ok ? rp_q[geom_q.stride_m1] : 8'd0;
  assign b_val   = seen_q ? mem_rdata_q : 8'd0;
  assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

  always_comb begin
    case (filt_q)
      FILT_SUB:   pred = a_val;
      FILT_UP:    pred = b_val;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a_val, b_val, c_val);
      default:    pred = 8'd0;
    endcase
  end

  always_comb begin
    pos_d        = pos_q;
    filt_d       = filt_q;
    await_d      = await_q;
    err_d        = err_q;
    seen_d       = seen_q;
    rc_d         = rc_q;
    rp_d         = rp_q;
    mem_we       = 1'b0;
    out_byte_d   = in_byte_i;
    byte_valid_d = 1'b1;
    err_v        = err_q;
    restart      = cfg_restart;

    if (in_acc) begin
      if ((geom_q.png || geom_q.tiff) && err_v == ST_OK && geom_q.bad_len) begin
        err_v = ST_LONG;
      end
      if (err_v == ST_OK && geom_q.png) begin
        if (await_q) begin
          if (in_byte_i > 8'(FILT_PAETH)) begin
            err_v = ST_BAD_TAG;
          end else begin
            filt_d       = in_byte_i[2:0];
            await_d      = 1'b0;
            pos_d        = '0;
            out_byte_d   = 8'd0;
            byte_valid_d = 1'b0;
          end
        end else begin
          out_byte_d = in_byte_i + pred;
          mem_we     = 1'b1;
          for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            rc_d[i] = rc_q[i-1];
            rp_d[i] = rp_q[i-1];
          end
          rc_d[0] = out_byte_d;
          rp_d[0] = b_val;
          if (pos_q == geom_q.last_pos) begin
            pos_d   = '0;
            await_d = 1'b1;
            seen_d  = 1'b1;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        if (end_of_stream_i && err_v == ST_OK && !await_d) begin
          err_v = ST_PARTIAL;
        end
      end else if (err_v == ST_OK && geom_q.tiff) begin
        out_byte_d = in_byte_i + a_val;
        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
          rc_d[i] = rc_q[i-1];
          rp_d[i] = rp_q[i-1];
        end
        rc_d[0] = out_byte_d;
        rp_d[0] = 8'd0;
        if (pos_q == geom_q.last_pos) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
        if (end_of_stream_i && pos_d != '0) begin
          err_v = ST_PARTIAL;
        end
      end
      err_d = err_v;
      if (end_of_stream_i) begin
        restart = 1'b1;
      end
    end

    if (restart) begin
      pos_d   = '0;
      filt_d  = FILT_NONE;
      await_d = 1'b1;
      err_d   = ST_OK;
      seen_d  = 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        rc_d[i] = 8'd0;
        rp_d[i] = 8'd0;
      end
    end
  end

  assign mem_wdata = out_byte_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      filt_q  <= FILT_NONE;
      await_q <= 1'b1;
      err_q   <= ST_OK;
      seen_q  <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        rc_q[i] <= 8'd0;
        rp_q[i] <= 8'd0;
      end
    end else begin
      pos_q   <= pos_d;
      filt_q  <= filt_d;
      await_q <= await_d;
      err_q   <= err_d;
      seen_q  <= seen_d;
      rc_q    <= rc_d;
      rp_q    <= rp_d;
    end
  end

  // Line buffer: write the current position, prefetch the next one; bypass on a hit
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prior_mem[pos_q] <= mem_wdata;
    end
    if (mem_we && pos_q == pos_d) begin
      mem_rdata_q <= mem_wdata;
    end else begin
      mem_rdata_q <= prior_mem[pos_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      done_q       <= end_of_stream_i;
      status_q     <= err_v;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign stream_done_o = done_q;
  assign status_o      = status_q;

endmodule

### verif/png_tiff_predictor_undo_checker.sv
`timescale 1ns / 1ps
// Scoreboard for png_tiff_predictor_undo_unit: tracks register writes, predicts each result
// from the accepted input bytes and compares the output channel in order.
// Depends on ptpu_pkg.
module png_tiff_predictor_undo_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [7:0]                      in_byte_i,
  input  logic                            end_of_stream_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [7:0]                      out_byte_i,
  input  logic                            byte_valid_i,
  input  logic                            stream_done_i,
  input  logic [1:0]                      status_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [ptpu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptpu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import ptpu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       done;
    logic [1:0] status;
  } undo_result_t;

  undo_result_t rebuilt_q[$];

  // Configuration copy
  logic [1:0]  cfg_mode;
  logic [12:0] cfg_cols;
  logic [2:0]  cfg_colors;
  logic [4:0]  cfg_bpc;

  // Stream state
  logic [7:0]  prev_line [LINE_BYTES];
  logic [7:0]  left_hist [MAX_PIXEL_BYTES];
  logic [7:0]  above_hist [MAX_PIXEL_BYTES];
  int unsigned row_pos;
  logic [2:0]  row_filter;
  bit          tag_next;
  logic [1:0]  sticky;

  task automatic clear_stream();
    foreach (prev_line[i]) prev_line[i] = 8'h00;
    foreach (left_hist[i]) begin
      left_hist[i]  = 8'h00;
      above_hist[i] = 8'h00;
    end
    row_pos    = 0;
    row_filter = FILT_NONE;
    tag_next   = 1'b1;
    sticky     = ST_OK;
  endtask

  task automatic shift_history(input logic [7:0] cur, input logic [7:0] above);
    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k]  = left_hist[k-1];
      above_hist[k] = above_hist[k-1];
    end
    left_hist[0]  = cur;
    above_hist[0] = above;
  endtask

  function automatic int paeth_pick(int a, int b, int c);
    int p;
    int da;
    int db;
    int dc;
    p  = a + b - c;
    da = (p > a) ? p - a : a - p;
    db = (p > b) ? p - b : b - p;
    dc = (p > c) ? p - c : c - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic rebuild_byte(input logic [7:0] din, input logic eos, output undo_result_t r);
    int unsigned row_len;
    int unsigned step;
    int unsigned x;
    int          a;
    int          b;
    int          c;
    int          guess;
    logic [7:0]  value;
    bit          data_ok;
    bit          png;
    bit          tiff;
    value   = din;
    data_ok = 1'b1;
    png     = (cfg_mode == MODE_PNG);
    tiff    = (cfg_mode == MODE_HORIZ) && (cfg_bpc == 5'd8);
    row_len = 0;
    step    = 1;
    if (png) begin
      row_len = (int'(cfg_cols) * int'(cfg_colors) * int'(cfg_bpc) + 7) / 8;
      step    = (int'(cfg_colors) * int'(cfg_bpc)) / 8;
    end else if (tiff) begin
      row_len = int'(cfg_cols) * int'(cfg_colors);
      step    = int'(cfg_colors);
    end
    if (step < 1) step = 1;
    if (step > MAX_PIXEL_BYTES) step = MAX_PIXEL_BYTES;

    if ((png || tiff) && sticky == ST_OK && (row_len == 0 || row_len > LINE_BYTES))
      sticky = ST_LONG;

    if (sticky == ST_OK && png) begin
      if (tag_next) begin
        if (din > 8'(FILT_PAETH)) begin
          sticky = ST_BAD_TAG;
        end else begin
          row_filter = din[2:0];
          tag_next   = 1'b0;
          row_pos    = 0;
          value      = 8'h00;
          data_ok    = 1'b0;
        end
      end else begin
        x = row_pos;
        b = int'(prev_line[x]);
        a = 0;
        c = 0;
        if (x >= step) begin
          a = int'(left_hist[step-1]);
          c = int'(above_hist[step-1]);
        end
        case (row_filter)
          FILT_SUB:   guess = a;
          FILT_UP:    guess = b;
          FILT_AVG:   guess = (a + b) >> 1;
          FILT_PAETH: guess = paeth_pick(a, b, c);
          default:    guess = 0;
        endcase
        value = 8'(int'(din) + guess);
        shift_history(value, 8'(b));
        prev_line[x] = value;
        x++;
        if (x >= row_len) begin
          x        = 0;
          tag_next = 1'b1;
        end
        row_pos = x;
      end
      // a stream may not stop inside a row or right after its tag
      if (eos && sticky == ST_OK && !tag_next) sticky = ST_PARTIAL;
    end else if (sticky == ST_OK && tiff) begin
      x     = row_pos;
      a     = (x >= step) ? int'(left_hist[step-1]) : 0;
      value = 8'(int'(din) + a);
      shift_history(value, 8'h00);
      x++;
      if (x >= row_len) x = 0;
      row_pos = x;
      if (eos && row_pos != 0) sticky = ST_PARTIAL;
    end

    r.data    = value;
    r.data_ok = data_ok;
    r.done    = eos;
    r.status  = sticky;
    if (eos) clear_stream();
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    bit listed;
    listed = 1'b1;
    case (idx)
      REG_MODE:    cfg_mode   = data[1:0];
      REG_COLUMNS: cfg_cols   = data[12:0];
      REG_COLORS:  cfg_colors = data[2:0];
      REG_BPC:     cfg_bpc    = data[4:0];
      default:     listed     = 1'b0;
    endcase
    if (listed) clear_stream();
  endtask

  task automatic check_result();
    undo_result_t want;
    bit           bad;
    if (rebuilt_q.size() == 0) begin
      $display("%0t: result with nothing expected, out_byte %02h status %0d",
               $time, out_byte_i, status_i);
      fail_count_o++;
    end else begin
      want = rebuilt_q.pop_front();
      bad  = 1'b0;
      if (out_byte_i !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte_i);
        bad = 1'b1;
      end
      if (byte_valid_i !== want.data_ok) begin
        $display("%0t: byte_valid expected %0b actual %0b", $time, want.data_ok, byte_valid_i);
        bad = 1'b1;
      end
      if (stream_done_i !== want.done) begin
        $display("%0t: stream_done expected %0b actual %0b", $time, want.done, stream_done_i);
        bad = 1'b1;
      end
      if (status_i !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
        bad = 1'b1;
      end
      if (bad) fail_count_o++;
      checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    undo_result_t r;
    if (!rst_ni) begin
      cfg_mode   = RST_MODE;
      cfg_cols   = RST_COLUMNS;
      cfg_colors = RST_COLORS;
      cfg_bpc    = RST_BPC;
      clear_stream();
      rebuilt_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_valid_i && cfg_ready_i) apply_cfg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        rebuild_byte(in_byte_i, end_of_stream_i, r);
        rebuilt_q.insert(rebuilt_q.size(), r);
      end
    end
    pending_o = rebuilt_q.size();
  end

endmodule

### verif/png_tiff_predictor_undo_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for png_tiff_predictor_undo_unit: drives byte streams and register writes
// with random idling on both channels. Depends on ptpu_pkg and the checker module.
module png_tiff_predictor_undo_unit_tb;
  import ptpu_pkg::*;

  // Stream shapes
  localparam int SHAPE_RANDOM  = 0;
  localparam int SHAPE_CLEAN   = 1;
  localparam int SHAPE_CUT     = 2;
  localparam int SHAPE_BAD_TAG = 3;
  localparam int SHAPE_NOISE   = 4;

  localparam int RANDOM_BYTES = 900;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            in_byte_i = 8'h00;
  logic                  end_of_stream_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  byte_valid_o;
  logic                  stream_done_o;
  logic [1:0]            status_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int          fail_count;
  int          pending;
  int          checked;
  bit          idle_on = 1'b1;
  int unsigned row_cap = 4;
  int unsigned bytes_sent = 0;
  int unsigned streams_sent = 0;
  int unsigned cfg_writes = 0;

  logic [1:0]  cur_mode = RST_MODE;
  logic [12:0] cur_cols = RST_COLUMNS;
  logic [2:0]  cur_colors = RST_COLORS;
  logic [4:0]  cur_bpc = RST_BPC;

  png_tiff_predictor_undo_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .stream_done_o   (stream_done_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  png_tiff_predictor_undo_checker scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .byte_valid_i    (byte_valid_o),
    .stream_done_i   (stream_done_o),
    .status_i        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending);
    $display("png_tiff_predictor_undo_unit_tb: FAIL");
    $finish;
  end

  // Result side: hold stall for a random number of cycles before each transaction
  initial begin : result_sink
    int hold;
    forever begin
      @(negedge clk_i);
      hold = idle_on ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int unsigned width);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(value);
    // junk above the register width must be dropped
    if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
      word = word | (CFG_DATA_W'($urandom) << width);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_geometry(input logic [1:0] mode, input logic [12:0] cols,
                              input logic [2:0] colors, input logic [4:0] bpc);
    cur_mode   = mode;
    cur_cols   = cols;
    cur_colors = colors;
    cur_bpc    = bpc;
    write_reg(REG_MODE, mode, 2);
    write_reg(REG_COLUMNS, cols, 13);
    write_reg(REG_COLORS, colors, 3);
    write_reg(REG_BPC, bpc, 5);
  endtask

  // Bytes per row for a well-formed stream, zero when the bytes just pass through
  function automatic int unsigned row_length();
    if (cur_mode == MODE_PNG)
      return (int'(cur_cols) * int'(cur_colors) * int'(cur_bpc) + 7) / 8;
    if (cur_mode == MODE_HORIZ && cur_bpc == 5'd8)
      return int'(cur_cols) * int'(cur_colors);
    return 0;
  endfunction

  function automatic logic [7:0] draw_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic pause_mid_stream();
    drain();
    case ($urandom_range(0, 2))
      0: write_reg(3'($urandom_range(REG_BPC + 1, 7)), $urandom, CFG_DATA_W);
      1: write_reg(REG_MODE, cur_mode, 2);
      default: ;
    endcase
  endtask

  task automatic send_stream(input int shape);
    logic [7:0]  seq[$];
    int unsigned rlen;
    int unsigned rows;
    int unsigned bad_row;
    int unsigned cut;
    bit          has_tags;
    rlen     = row_length();
    has_tags = (cur_mode == MODE_PNG);
    if (shape == SHAPE_RANDOM) begin
      case ($urandom_range(0, 9))
        7:       shape = SHAPE_CUT;
        8:       shape = SHAPE_BAD_TAG;
        9:       shape = SHAPE_NOISE;
        default: shape = SHAPE_CLEAN;
      endcase
    end
    if (rlen == 0 || rlen > LINE_BYTES || shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 24)) seq.insert(seq.size(), draw_byte());
    end else begin
      rows    = $urandom_range(1, row_cap);
      bad_row = (shape == SHAPE_BAD_TAG) ? $urandom_range(0, rows - 1) : rows;
      for (int r = 0; r < rows; r++) begin
        if (has_tags) begin
          if (r == bad_row)
            seq.insert(seq.size(), 8'($urandom_range(FILT_PAETH + 1, 255)));
          else seq.insert(seq.size(), 8'($urandom_range(FILT_NONE, FILT_PAETH)));
        end
        repeat (rlen) seq.insert(seq.size(), draw_byte());
      end
      if (shape == SHAPE_CUT) begin
        cut = $urandom_range(1, seq.size());
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) begin
      if ($urandom_range(0, 299) == 0) pause_mid_stream();
      send_byte(seq[i], i == seq.size() - 1);
    end
    streams_sent++;
  endtask

  task automatic random_geometry();
    logic [1:0]  mode;
    logic [12:0] cols;
    logic [2:0]  colors;
    logic [4:0]  bpc;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: mode = MODE_PNG;
      4, 5:       mode = MODE_HORIZ;
      6:          mode = MODE_PASS;
      default:    mode = 2'($urandom);
    endcase
    cols   = ($urandom_range(0, 4) != 0) ? 13'($urandom_range(1, 6))
                                         : 13'($urandom_range(0, 40));
    colors = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4)) : 3'($urandom);
    bpc    = ($urandom_range(0, 3) != 0) ? 5'(1 << $urandom_range(0, 4)) : 5'($urandom);
    if (mode == MODE_HORIZ && $urandom_range(0, 1) == 0) bpc = 5'd8;
    set_geometry(mode, cols, colors, bpc);
  endtask

  initial begin : stimulus
    int unsigned target;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Pass-through at the reset settings
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // One row per filter, then a lone tag at the end of the stream
    set_geometry(MODE_PNG, 13'd2, 3'd1, 5'd8);
    send_byte(8'(FILT_SUB), 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'(FILT_UP), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'(FILT_AVG), 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'(FILT_PAETH), 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'(FILT_NONE), 1'b1);
    // bad tag, then sticky pass-through
    send_byte(8'hC7, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain();

    set_geometry(MODE_HORIZ, 13'd2, 3'd1, 5'd8);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b1);
    drain();

    set_geometry(MODE_PNG, 13'd4097, 3'd1, 5'd8);
    send_byte(8'h00, 1'b1);
    drain();
    write_reg(3'($urandom_range(REG_BPC + 1, 7)), $urandom, CFG_DATA_W);

    // Long rows, wide pixels and oversized geometries, no idling
    idle_on = 1'b0;
    row_cap = 2;
    set_geometry(MODE_PNG, 13'd300, 3'd1, 5'd8);
    send_stream(SHAPE_CLEAN);
    drain();
    set_geometry(MODE_HORIZ, 13'd150, 3'd2, 5'd8);
    send_stream(SHAPE_CUT);
    drain();
    set_geometry(MODE_PNG, 13'd3, 3'd7, 5'd16);
    send_stream(SHAPE_CLEAN);
    drain();
    set_geometry(MODE_PNG, 13'd8191, 3'd7, 5'd31);
    send_stream(SHAPE_NOISE);
    drain();
    set_geometry(MODE_HORIZ, 13'd4096, 3'd2, 5'd8);
    send_stream(SHAPE_NOISE);
    drain();
    row_cap = 4;

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_geometry();
      repeat ($urandom_range(1, 3)) send_stream(SHAPE_RANDOM);
      drain();
    end

    $display("Covered %0d streams, %0d bytes and %0d register writes", streams_sent,
             bytes_sent, cfg_writes);
    $display("Compared %0d results, %0d failing", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("png_tiff_predictor_undo_unit_tb: PASS");
    end else begin
      $display("png_tiff_predictor_undo_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
